// ===== design/dcsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcsc_pkg: shared types and constants of the sparse column encoder
// Result kinds, register indexes, widths and the front-to-back command word.
// ----------------------------------------------------------------------------
package dcsc_pkg;

  localparam int unsigned MaxDim     = 256;
  localparam int unsigned DimW       = 9;
  localparam int unsigned PosW       = 8;
  localparam int unsigned CountW     = 17;
  localparam int unsigned ValueW     = 64;
  localparam int unsigned ThreshW    = 63;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned QueueDepth = 2;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
  localparam logic [ThreshW-1:0] ThreshReset = 63'h3E112E0BE826D695;

  typedef enum logic [1:0] {
    KIND_ENTRY       = 2'd0,
    KIND_POINTER     = 2'd1,
    KIND_SHAPE_ERROR = 2'd2
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MODE      = 2'd0,
    REG_ROW_COUNT = 2'd1,
    REG_COL_COUNT = 2'd2,
    REG_THRESHOLD = 2'd3
  } reg_idx_e;

  // One classified element: which results it causes and their payload.
  typedef struct packed {
    logic              shape_err;
    logic              first_ptr;
    logic              entry;
    logic              col_end;
    logic              final_col;
    logic [ValueW-1:0] value;
    logic [PosW-1:0]   row;
    logic [CountW-1:0] count;
  } cmd_t;

endpackage

// ===== design/dcsc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcsc_front: element classifier
// Tracks row, column and nonzero count; turns each element into a command.
// ----------------------------------------------------------------------------
module dcsc_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dcsc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dcsc_pkg::ValueW-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [dcsc_pkg::ValueW-1:0]   element_value_i,
  output logic                          cmd_valid_o,
  input  logic                          cmd_full_i,
  output dcsc_pkg::cmd_t                cmd_o
);
  import dcsc_pkg::*;

  logic               mode_q;
  logic [DimW-1:0]    rows_q, cols_q;
  logic [ThreshW-1:0] thresh_q;
  logic [PosW-1:0]    row_q, row_d, col_q, col_d;
  logic [CountW-1:0]  cnt_q, cnt_d;
  logic [DimW-1:0]    rows_eff, cols_eff;
  logic               take, keep, nz, end_col, end_mat;

  function automatic logic [DimW-1:0] eff_dim(input logic [DimW-1:0] r);
    logic [DimW-1:0] v;
    v = r;
    if (r == '0) v = DimW'(1);
    else if (r > DimW'(MaxDim)) v = DimW'(MaxDim);
    return v;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      rows_q   <= DimW'(1);
      cols_q   <= DimW'(1);
      thresh_q <= ThreshReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODE:      mode_q   <= cfg_data_i[0];
        REG_ROW_COUNT: rows_q   <= cfg_data_i[DimW-1:0];
        REG_COL_COUNT: cols_q   <= cfg_data_i[DimW-1:0];
        REG_THRESHOLD: thresh_q <= cfg_data_i[ThreshW-1:0];
        default: ;
      endcase
    end
  end

  assign rows_eff   = eff_dim(rows_q);
  assign cols_eff   = eff_dim(cols_q);
  assign in_stall_o = cmd_full_i;
  assign take       = in_valid_i && !cmd_full_i;

  always_comb begin
    keep    = !mode_q || (row_q <= col_q);
    nz      = keep && (element_value_i[ThreshW-1:0] >= thresh_q);
    end_col = ({1'b0, row_q} + DimW'(1)) >= rows_eff;
    end_mat = ({1'b0, col_q} + DimW'(1)) >= cols_eff;
    cnt_d   = (nz && cnt_q != CountMax) ? cnt_q + CountW'(1) : cnt_q;
    row_d   = end_col ? '0 : row_q + PosW'(1);
    col_d   = end_col ? (end_mat ? '0 : col_q + PosW'(1)) : col_q;
    cmd_o.shape_err = mode_q && (rows_eff != cols_eff);
    cmd_o.first_ptr = (row_q == '0) && (col_q == '0);
    cmd_o.entry     = nz;
    cmd_o.col_end   = end_col;
    cmd_o.final_col = end_mat;
    cmd_o.value     = element_value_i;
    cmd_o.row       = row_q;
    cmd_o.count     = cnt_d;
  end

  assign cmd_valid_o = in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      cnt_q <= '0;
    end else if (take && !cmd_o.shape_err) begin
      row_q <= row_d;
      col_q <= col_d;
      cnt_q <= (end_col && end_mat) ? '0 : cnt_d;
    end
  end

endmodule

// ===== design/dcsc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcsc_queue: command queue
// Small FIFO between the classifier and the result sequencer.
// ----------------------------------------------------------------------------
module dcsc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dcsc_pkg::cmd_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output dcsc_pkg::cmd_t pop_data_o
);
  import dcsc_pkg::*;

  cmd_t       mem_q [QueueDepth];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o     = cnt_q == 2'(QueueDepth);
  assign empty_o    = cnt_q == '0;
  assign pop_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

// ===== design/dcsc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcsc_back: result sequencer
// Plays out up to three result words per command into an output register.
// ----------------------------------------------------------------------------
module dcsc_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cmd_empty_i,
  input  dcsc_pkg::cmd_t               cmd_i,
  output logic                         cmd_pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   kind_o,
  output logic [dcsc_pkg::ValueW-1:0]  entry_value_o,
  output logic [7:0]                   row_index_o,
  output logic [dcsc_pkg::CountW-1:0]  column_pointer_o,
  output logic                         last_o
);
  import dcsc_pkg::*;

  // Steps done on the head command: bit 0 first pointer, bit 1 entry.
  logic [1:0] done_q, done_d;
  logic       valid_q, load, pend_first, pend_entry, emit;
  logic [1:0]        kind_d, kind_q;
  logic [ValueW-1:0] val_d, val_q;
  logic [PosW-1:0]   row_d, row_q;
  logic [CountW-1:0] ptr_d, ptr_q;
  logic              last_d, last_q;

  assign load       = !cmd_empty_i && (!valid_q || !out_stall_i);
  assign pend_first = cmd_i.first_ptr && !done_q[0];
  assign pend_entry = cmd_i.entry && !done_q[1];

  always_comb begin
    kind_d    = KIND_POINTER;
    val_d     = '0;
    row_d     = '0;
    ptr_d     = '0;
    last_d    = 1'b0;
    done_d    = done_q;
    cmd_pop_o = 1'b0;
    emit      = 1'b1;
    if (cmd_i.shape_err) begin
      kind_d    = KIND_SHAPE_ERROR;
      cmd_pop_o = load;
    end else if (pend_first) begin
      done_d[0] = 1'b1;
      cmd_pop_o = load && !cmd_i.entry && !cmd_i.col_end;
    end else if (pend_entry) begin
      kind_d    = KIND_ENTRY;
      val_d     = cmd_i.value;
      row_d     = cmd_i.row;
      done_d[1] = 1'b1;
      cmd_pop_o = load && !cmd_i.col_end;
    end else if (cmd_i.col_end) begin
      ptr_d     = cmd_i.count;
      last_d    = cmd_i.final_col;
      cmd_pop_o = load;
    end else begin
      // drop a command that causes no word
      emit      = 1'b0;
      cmd_pop_o = load;
    end
    if (cmd_pop_o) done_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      done_q  <= '0;
    end else begin
      if (load) begin
        valid_q <= emit;
        done_q  <= done_d;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= kind_d;
      val_q  <= val_d;
      row_q  <= row_d;
      ptr_q  <= ptr_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o      = valid_q;
  assign kind_o           = kind_q;
  assign entry_value_o    = val_q;
  assign row_index_o      = row_q;
  assign column_pointer_o = ptr_q;
  assign last_o           = last_q;

endmodule

// ===== design/dense_to_csc_sparse_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dense_to_csc_sparse_encoder: dense matrix to compressed sparse column
// Streams column-major double elements in, streams CSC pointer/entry words out.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_stall_o | element_value_i
//  out     | output    | out_valid_o/out_stall_i | kind, entry_value, row_index,
//          |           |                         | column_pointer, last
//  cfg     | input     | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// Each element becomes one command in a two-deep queue; the sequencer then
// emits one result word per cycle while out_stall_i is low, up to three words
// per command, all through the single result port.
// Reset clears position, count, queue and output valid; registers take their
// reset values. Input stalls only when the queue is full; an output stall
// holds the result register while the classifier keeps filling the queue.
// ----------------------------------------------------------------------------
module dense_to_csc_sparse_encoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dcsc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dcsc_pkg::ValueW-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [63:0]                   element_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    kind_o,
  output logic [63:0]                   entry_value_o,
  output logic [7:0]                    row_index_o,
  output logic [16:0]                   column_pointer_o,
  output logic                          last_o
);
  import dcsc_pkg::*;

  cmd_t cmd_in, cmd_out;
  logic cmd_valid, full, empty, pop;

  dcsc_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .element_value_i,
    .cmd_valid_o(cmd_valid), .cmd_full_i(full), .cmd_o(cmd_in)
  );

  // Push exactly when the front accepts an element.
  dcsc_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(cmd_valid && !full), .push_data_i(cmd_in), .full_o(full),
    .pop_i(pop), .empty_o(empty), .pop_data_o(cmd_out)
  );

  dcsc_back u_back (
    .clk_i, .rst_ni, .cmd_empty_i(empty), .cmd_i(cmd_out), .cmd_pop_o(pop),
    .out_valid_o, .out_stall_i, .kind_o, .entry_value_o, .row_index_o,
    .column_pointer_o, .last_o
  );

endmodule
